[sv/dithered_pwm_duty_modulator_unit_assert.svh]
// assertion macros shared by the checker
`ifndef DITHERED_PWM_DUTY_MODULATOR_UNIT_ASSERT_SVH
`define DITHERED_PWM_DUTY_MODULATOR_UNIT_ASSERT_SVH

// implication in the same cycle
`define DPDM_ASSERT_NOW(lbl, ck, dis, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (dis) (ante) |-> (cons)) \
    else $error("dpdm assertion failed");

// implication in the next cycle
`define DPDM_ASSERT_NEXT(lbl, ck, dis, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (dis) (ante) |=> (cons)) \
    else $error("dpdm assertion failed");

`endif

[sv/dpdm_pkg.sv]
package dpdm_pkg;

  localparam int DUTY_W     = 8;
  localparam int WIDE_W     = 16;
  localparam int PCT_W      = 10;
  localparam int DIV_STEPS  = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 16;

  localparam logic [DUTY_W-1:0] DUTY_MAX    = 8'hFF;
  localparam logic [WIDE_W-1:0] PCT_SCALE   = 16'd100;
  // floor(x / 100) == (x * RECIP_100) >> RECIP_SHIFT for any 16-bit x
  localparam logic [16:0]       RECIP_100   = 17'd83887;
  localparam int                RECIP_SHIFT = 23;

  localparam bit SERVICE_BUILD_DEF = 1'b0;

  typedef enum logic [1:0] {
    CMD_RAW  = 2'd0,
    CMD_FMT  = 2'd1,
    CMD_TICK = 2'd2,
    CMD_NOP  = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DUTY_FLOOR  = 3'd0,
    REG_UPPER_POINT = 3'd1,
    REG_DUTY_CAP    = 3'd2,
    REG_AMP_MAX     = 3'd3,
    REG_AMP_MIN     = 3'd4,
    REG_LOW_MARGIN  = 3'd5,
    REG_HIGH_MARGIN = 3'd6,
    REG_DITHER_EN   = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic raw_wr;
    logic fmt_load;
    logic prep;
    logic div_step;
    logic mul;
    logic scale;
    logic amp;
    logic margin;
    logic tick;
  } dp_cmd_t;

  typedef struct packed {
    logic no_dither;
    logic use_min;
    logic out_free;
  } dp_stat_t;

endpackage

[sv/dpdm_ctrl.sv]
module dpdm_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  dpdm_pkg::cmd_t    in_cmd,
  output logic              in_ready,
  input  dpdm_pkg::dp_stat_t stat,
  output dpdm_pkg::dp_cmd_t  cmd
);
  import dpdm_pkg::*;

  localparam int CNT_W = $clog2(DIV_STEPS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_MUL,
    ST_SCALE,
    ST_AMP,
    ST_MARGIN,
    ST_TICK
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] cnt;
  logic             take;

  assign in_ready = (state == ST_IDLE);
  assign take     = in_ready && in_valid;

  always_comb begin
    cmd          = '0;
    cmd.raw_wr   = take && (in_cmd == CMD_RAW);
    cmd.fmt_load = take && (in_cmd == CMD_FMT);
    cmd.prep     = (state == ST_PREP);
    cmd.div_step = (state == ST_DIV);
    cmd.mul      = (state == ST_MUL);
    cmd.scale    = (state == ST_SCALE);
    cmd.amp      = (state == ST_AMP);
    cmd.margin   = (state == ST_MARGIN);
    cmd.tick     = (state == ST_TICK) && stat.out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (take) begin
            case (in_cmd)
              CMD_FMT:  state <= ST_PREP;
              CMD_TICK: state <= ST_TICK;
              default:  state <= ST_IDLE;
            endcase
          end
        end
        ST_PREP: begin
          cnt <= '0;
          if (stat.no_dither) begin
            state <= ST_IDLE;
          end else if (stat.use_min) begin
            state <= ST_MARGIN;
          end else begin
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(DIV_STEPS - 1)) begin
            state <= ST_MUL;
          end
        end
        ST_MUL:    state <= ST_SCALE;
        ST_SCALE:  state <= ST_AMP;
        ST_AMP:    state <= ST_MARGIN;
        ST_MARGIN: state <= ST_IDLE;
        ST_TICK: begin
          if (stat.out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

[sv/dpdm_dp.sv]
module dpdm_dp #(
  parameter bit SERVICE_BUILD = dpdm_pkg::SERVICE_BUILD_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [dpdm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dpdm_pkg::DUTY_W-1:0]         cfg_data,
  input  logic [dpdm_pkg::DUTY_W-1:0]         req,
  input  dpdm_pkg::dp_cmd_t                   cmd,
  output dpdm_pkg::dp_stat_t                  stat,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [dpdm_pkg::OUT_DATA_W-1:0]     out_data,
  output logic                                out_high
);
  import dpdm_pkg::*;

  // config
  logic [DUTY_W-1:0] duty_floor, upper_point, duty_cap, amp_max, amp_min;
  logic [DUTY_W-1:0] low_margin, high_margin;
  logic              dither_en;

  // state
  logic [DUTY_W-1:0] buf_duty, buf_amp, work_duty, work_amp;
  logic              buf_ready, phase;

  // formatted write scratch
  logic [DUTY_W-1:0] d, a;
  logic [WIDE_W-1:0] quo, rem, dvs, prod;
  logic [PCT_W-1:0]  pct;

  always_ff @(posedge clk) begin
    if (rst) begin
      duty_floor  <= '0;
      upper_point <= DUTY_MAX;
      duty_cap    <= DUTY_MAX;
      amp_max     <= '0;
      amp_min     <= '0;
      low_margin  <= '0;
      high_margin <= DUTY_MAX;
      dither_en   <= 1'b0;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_DUTY_FLOOR:  duty_floor  <= cfg_data;
        REG_UPPER_POINT: upper_point <= cfg_data;
        REG_DUTY_CAP:    duty_cap    <= cfg_data;
        REG_AMP_MAX:     amp_max     <= cfg_data;
        REG_AMP_MIN:     amp_min     <= cfg_data;
        REG_LOW_MARGIN:  low_margin  <= cfg_data;
        REG_HIGH_MARGIN: high_margin <= cfg_data;
        REG_DITHER_EN:   dither_en   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // clamp to floor and cap, cap wins; the floor is skipped in a service build with dither off
  logic [DUTY_W-1:0] d_clamp;
  always_comb begin
    d_clamp = req;
    if (!SERVICE_BUILD || dither_en) begin
      if (d_clamp < duty_floor) d_clamp = duty_floor;
    end
    if (d_clamp > duty_cap) d_clamp = duty_cap;
  end

  // slope setup, 16-bit wrap
  logic [WIDE_W-1:0] d_off, span, num, amp_diff;
  logic [31:0]       num_full, prod_full;
  logic [32:0]       scaled;
  always_comb begin
    d_off     = {8'b0, d} - {8'b0, duty_floor};
    span      = {8'b0, upper_point} - {8'b0, duty_floor};
    num_full  = d_off * PCT_SCALE;
    num       = num_full[WIDE_W-1:0];
    amp_diff  = {8'b0, amp_max} - {8'b0, amp_min};
    prod_full = quo * amp_diff;
    scaled    = prod * RECIP_100;
  end

  // two restoring divide steps per cycle
  logic [WIDE_W:0]   r1, r2;
  logic              ge1, ge2;
  logic [WIDE_W-1:0] r1s, r2s, quo1, quo2;
  always_comb begin
    r1   = {rem, quo[WIDE_W-1]};
    ge1  = (r1 >= {1'b0, dvs});
    r1s  = ge1 ? WIDE_W'(r1 - {1'b0, dvs}) : r1[WIDE_W-1:0];
    quo1 = {quo[WIDE_W-2:0], ge1};
    r2   = {r1s, quo1[WIDE_W-1]};
    ge2  = (r2 >= {1'b0, dvs});
    r2s  = ge2 ? WIDE_W'(r2 - {1'b0, dvs}) : r2[WIDE_W-1:0];
    quo2 = {quo1[WIDE_W-2:0], ge2};
  end

  // margin clip, only one margin applies
  logic signed [9:0] hi_room, lo_room, a_s;
  logic [DUTY_W-1:0] a_clip;
  always_comb begin
    hi_room = $signed({2'b0, high_margin}) - $signed({2'b0, d});
    lo_room = $signed({2'b0, d}) - $signed({2'b0, low_margin});
    a_s     = $signed({2'b0, a});
    if (a_s > hi_room) begin
      a_clip = hi_room[DUTY_W-1:0];
    end else if (a_s > lo_room) begin
      a_clip = lo_room[DUTY_W-1:0];
    end else begin
      a_clip = a;
    end
  end

  // period tick arithmetic
  logic [DUTY_W-1:0] src_duty, src_amp, new_duty;
  logic [DUTY_W:0]   sum, dif;
  always_comb begin
    src_duty = buf_ready ? buf_duty : work_duty;
    src_amp  = buf_ready ? buf_amp  : work_amp;
    sum      = {1'b0, src_duty} + {1'b0, src_amp};
    dif      = {1'b0, src_duty} - {1'b0, src_amp};
    if (!dither_en) begin
      new_duty = src_duty;
    end else if (!phase) begin
      new_duty = dif[DUTY_W] ? DUTY_MAX : dif[DUTY_W-1:0];
    end else begin
      new_duty = sum[DUTY_W] ? DUTY_MAX : sum[DUTY_W-1:0];
    end
  end

  assign stat.no_dither = !dither_en;
  assign stat.use_min   = (d >= upper_point) || (span == '0);
  assign stat.out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      buf_duty  <= '0;
      buf_amp   <= '0;
      buf_ready <= 1'b0;
      work_duty <= '0;
      work_amp  <= '0;
      phase     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.raw_wr) begin
        buf_duty  <= req;
        buf_amp   <= '0;
        buf_ready <= 1'b1;
      end
      if (cmd.prep && !dither_en) begin
        buf_duty  <= d;
        buf_amp   <= '0;
        buf_ready <= 1'b1;
      end
      if (cmd.margin) begin
        buf_duty  <= d;
        buf_amp   <= a_clip;
        buf_ready <= 1'b1;
      end
      if (cmd.tick) begin
        work_duty <= new_duty;
        work_amp  <= src_amp;
        if (dither_en) phase <= !phase;
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.fmt_load) d <= d_clamp;
    if (cmd.prep) begin
      a   <= amp_min;
      quo <= num;
      rem <= '0;
      dvs <= span;
    end
    if (cmd.div_step) begin
      quo <= quo2;
      rem <= r2s;
    end
    if (cmd.mul)   prod <= prod_full[WIDE_W-1:0];
    if (cmd.scale) pct  <= scaled[RECIP_SHIFT +: PCT_W];
    if (cmd.amp) begin
      a <= (pct > {2'b0, amp_max}) ? amp_min : amp_max - pct[DUTY_W-1:0];
    end
    if (cmd.tick) begin
      out_data <= {{(OUT_DATA_W - DUTY_W - 1){1'b0}}, new_duty, 1'b0};
      out_high <= dither_en && phase;
    end
  end

endmodule

[sv/dithered_pwm_duty_modulator_unit.sv]
// channel   dir  fields (lsb first)                      accepted when
// s_axis    in   tdata: duty_request[7:0]                 s_axis_tvalid & s_axis_tready
//                tuser: command[1:0]
// m_axis    out  tdata: duty_value[8:0], zero pad to 16   m_axis_tvalid & m_axis_tready
//                tuser: dither_high
// cfg       in   cfg_index selects, cfg_data[7:0] value   cfg_we
//
// raw write: next request taken in the following cycle
// formatted write: prep only without dither, prep then margin with amplitude at its minimum,
//   else prep, the 2-bit-per-cycle divider, multiply, scale, amplitude and margin
// tick: loads the output register once it is free, waits while it is held
// rst is synchronous and clears control, config and duty state; no clearing pass
// a new request is taken while a finished result still waits in the output register
module dithered_pwm_duty_modulator_unit #(
  parameter bit SERVICE_BUILD = dpdm_pkg::SERVICE_BUILD_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // request channel
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [dpdm_pkg::IN_DATA_W-1:0]    s_axis_tdata,   // duty_request[7:0]
  input  logic [1:0]                        s_axis_tuser,   // command[1:0]
  // result channel
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [dpdm_pkg::OUT_DATA_W-1:0]   m_axis_tdata,   // duty_value[8:0], zeros
  output logic                              m_axis_tuser,   // dither_high
  // register writes
  input  logic                              cfg_we,
  input  logic [dpdm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dpdm_pkg::DUTY_W-1:0]       cfg_data
);
  import dpdm_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencer: decodes the request kind and steps the formatted-write path
  dpdm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_cmd   (cmd_t'(s_axis_tuser)),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath: config, duty buffers, divider, scaling and the output register
  dpdm_dp #(
    .SERVICE_BUILD (SERVICE_BUILD)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (s_axis_tdata),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .out_high  (m_axis_tuser)
  );

endmodule

[sv/dpdm_chk.sv]
`include "dithered_pwm_duty_modulator_unit_assert.svh"

module dpdm_chk (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [1:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic        m_axis_tuser
);
  import dpdm_pkg::*;

  // result held until taken
  `DPDM_ASSERT_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

  // duty is always doubled, so even and at most 510
  `DPDM_ASSERT_NOW(a_duty_even, clk, rst, m_axis_tvalid, !m_axis_tdata[0] && (m_axis_tdata[15:9] == 7'd0))

  // nothing pending out of reset
  `DPDM_ASSERT_NEXT(a_rst_clear, clk, 1'b0, rst, !m_axis_tvalid && s_axis_tready)

  // a new result only follows an accepted request
  `DPDM_ASSERT_NOW(a_out_cause, clk, rst, m_axis_tvalid && !$past(m_axis_tvalid) && !$past(rst), !$past(s_axis_tready) || $past(s_axis_tvalid && s_axis_tuser == CMD_TICK))

endmodule

bind dithered_pwm_duty_modulator_unit dpdm_chk u_chk (.*);

[test/tb_dithered_pwm_duty_modulator_unit.sv]
`timescale 1ns / 1ps

module tb_dithered_pwm_duty_modulator_unit;
  import dpdm_pkg::*;

  // build option of the instance below, the duty model honors it too
  localparam bit SVC_BUILD = 1'b0;
  // percent of cycles that each side sits idle
  localparam int IDLE_PCT = 32;
  // a formatted write runs the whole slope path with no result, so settle waits well past it
  localparam int SETTLE_CYCLES = 32;
  localparam int STALL_LIMIT = 4000;
  localparam int RANDOM_PHASES = 17;
  localparam int ITEMS_PER_PHASE = 100;

  typedef struct packed {
    logic [8:0] duty_value;
    logic       dither_high;
  } duty_result_t;

  // one row of the directed part: either a register write or a request
  typedef struct packed {
    logic         is_reg;
    reg_idx_t     idx;
    cmd_t         cmd;
    logic [7:0]   data;
    logic         typed;      // result given in the row, not taken from the duty model
    duty_result_t typed_res;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = CMD_NOP;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = REG_DUTY_FLOOR;
  logic [7:0]  cfg_data = '0;

  // no idling on either side while set
  bit quiet = 1'b0;
  int mismatches = 0;
  int stall_cycles = 0;

  // duties the block still owes, oldest first
  duty_result_t pending_results[$];

  // register copy of the duty model
  logic [7:0] mod_floor, mod_upper, mod_cap, mod_amp_max, mod_amp_min;
  logic [7:0] mod_low_margin, mod_high_margin;
  logic       mod_dither_en;
  // duty state of the model
  logic [7:0]  held_duty, held_amp;
  logic        held_valid;
  logic [15:0] work_duty;
  logic [7:0]  work_amp;
  logic        phase_up;

  dithered_pwm_duty_modulator_unit #(
    .SERVICE_BUILD(SVC_BUILD)
  ) DUT (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),   // duty_request[7:0]
    .s_axis_tuser (s_axis_tuser),   // command[1:0]
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),   // duty_value[8:0], zeros above
    .m_axis_tuser (m_axis_tuser),   // dither_high
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // directed part: extremes, every command, and the corner cases of the dither math
  dir_row_t directed_rows [43] = '{
    // tick straight after reset, nothing written yet
    '{1'b0, REG_DUTY_FLOOR, CMD_TICK, 8'h00, 1'b1, '{9'd0, 1'b0}},
    // command three is ignored
    '{1'b0, REG_DUTY_FLOOR, CMD_NOP,  8'hA5, 1'b0, '{9'd0, 1'b0}},
    '{1'b0, REG_DUTY_FLOOR, CMD_RAW,  8'hFF, 1'b0, '{9'd0, 1'b0}},
    '{1'b0, REG_DUTY_FLOOR, CMD_TICK, 8'h00, 1'b1, '{9'd510, 1'b0}},
    '{1'b0, REG_DUTY_FLOOR, CMD_RAW,  8'h00, 1'b0, '{9'd0, 1'b0}},
    '{1'b0, REG_DUTY_FLOOR, CMD_TICK, 8'h00, 1'b1, '{9'd0, 1'b0}},
    '{1'b0, REG_DUTY_FLOOR, CMD_FMT,  8'h80, 1'b0, '{9'd0, 1'b0}},
    '{1'b0, REG_DUTY_FLOOR, CMD_TICK, 8'h00, 1'b1, '{9'd256, 1'b0}},
    // cap below floor, upper point equal to floor gives a zero slope divisor
    '{1'b1, REG_DUTY_FLOOR,  CMD_NOP, 8'd100, 1'b0, '{9'd0, 1'b0}},
    '{1'b1, REG_UPPER_POINT, CMD_NOP, 8'd100, 1'b0, '{9'd0, 1'b0}},
    '{1'b1, REG_DUTY_CAP,    CMD_NOP, 8'd50,  1'b0, '{9'd0, 1'b0}},
    '{1'b1, REG_AMP_MAX,     CMD_NOP, 8'd40,  1'b0, '{9'd0, 1'b0}},
    '{1'b1, REG_AMP_MIN,     CMD_NOP, 8'd20,  1'b0, '{9'd0, 1'b0}},
    '{1'b1, REG_DITHER_EN,   CMD_NOP, 8'h01,  1'b0, '{9'd0, 1'b0}},
    '{1'b0, REG_DUTY_FLOOR, CMD_FMT,  8'h00, 1'b0, '{9'd0, 1'b0}},
    '{1'b0, REG_DUTY_FLOOR, CMD_TICK, 8'h00, 1'b0, '{9'd0, 1'b0}},
    '{1'b0, REG_DUTY_FLOOR, CMD_TICK, 8'h00, 1'b0, '{9'd0, 1'b0}},
    // amplitude minimum above maximum
    '{1'b1, REG_DUTY_FLOOR,  CMD_NOP, 8'd10,  1'b0, '{9'd0, 1'b0}},
    '{1'b1, REG_UPPER_POINT, CMD_NOP, 8'd200, 1'b0, '{9'd0, 1'b0}},
    '{1'b1, REG_DUTY_CAP,    CMD_NOP, 8'hFF,  1'b0, '{9'd0, 1'b0}},
    '{1'b1, REG_AMP_MAX,     CMD_NOP, 8'd10,  1'b0, '{9'd0, 1'b0}},
    '{1'b1, REG_AMP_MIN,     CMD_NOP, 8'd60,  1'b0, '{9'd0, 1'b0}},
    '{1'b0, REG_DUTY_FLOOR, CMD_FMT,  8'd50, 1'b0, '{9'd0, 1'b0}},
    '{1'b0, REG_DUTY_FLOOR, CMD_TICK, 8'h00, 1'b0, '{9'd0, 1'b0}},
    '{1'b0, REG_DUTY_FLOOR, CMD_TICK, 8'h00, 1'b0, '{9'd0, 1'b0}},
    // low margin above duty: big amplitude, subtract wraps and clamps
    '{1'b1, REG_AMP_MAX,     CMD_NOP, 8'd200, 1'b0, '{9'd0, 1'b0}},
    '{1'b1, REG_AMP_MIN,     CMD_NOP, 8'd0,   1'b0, '{9'd0, 1'b0}},
    '{1'b1, REG_DUTY_FLOOR,  CMD_NOP, 8'd0,   1'b0, '{9'd0, 1'b0}},
    '{1'b1, REG_UPPER_POINT, CMD_NOP, 8'hFF,  1'b0, '{9'd0, 1'b0}},
    '{1'b1, REG_LOW_MARGIN,  CMD_NOP, 8'd30,  1'b0, '{9'd0, 1'b0}},
    '{1'b0, REG_DUTY_FLOOR, CMD_FMT,  8'd10, 1'b0, '{9'd0, 1'b0}},
    '{1'b0, REG_DUTY_FLOOR, CMD_TICK, 8'h00, 1'b0, '{9'd0, 1'b0}},
    '{1'b0, REG_DUTY_FLOOR, CMD_TICK, 8'h00, 1'b0, '{9'd0, 1'b0}},
    // high margin below duty
    '{1'b1, REG_HIGH_MARGIN, CMD_NOP, 8'd20,  1'b0, '{9'd0, 1'b0}},
    '{1'b1, REG_LOW_MARGIN,  CMD_NOP, 8'd0,   1'b0, '{9'd0, 1'b0}},
    '{1'b0, REG_DUTY_FLOOR, CMD_FMT,  8'd100, 1'b0, '{9'd0, 1'b0}},
    '{1'b0, REG_DUTY_FLOOR, CMD_TICK, 8'h00,  1'b0, '{9'd0, 1'b0}},
    '{1'b0, REG_DUTY_FLOOR, CMD_TICK, 8'h00,  1'b0, '{9'd0, 1'b0}},
    // raw write with dither on carries zero amplitude
    '{1'b0, REG_DUTY_FLOOR, CMD_RAW,  8'h80, 1'b0, '{9'd0, 1'b0}},
    '{1'b0, REG_DUTY_FLOOR, CMD_TICK, 8'h00, 1'b0, '{9'd0, 1'b0}},
    '{1'b0, REG_DUTY_FLOOR, CMD_TICK, 8'h00, 1'b0, '{9'd0, 1'b0}},
    // dither off again, phase must hold
    '{1'b1, REG_DITHER_EN,   CMD_NOP, 8'h00,  1'b0, '{9'd0, 1'b0}},
    '{1'b0, REG_DUTY_FLOOR, CMD_TICK, 8'h00, 1'b0, '{9'd0, 1'b0}}
  };

  // dither amplitude for a clamped duty, 16-bit wrap as in the firmware
  function automatic logic [7:0] dither_amplitude(input logic [7:0] d);
    logic [15:0] span, slope_div, t, amp_span;
    logic [31:0] prod;
    logic [7:0]  a;
    int          hi_room, lo_room;
    if (d >= mod_upper) begin
      a = mod_amp_min;
    end else begin
      span = {8'h00, d} - {8'h00, mod_floor};
      t = span * 16'd100;
      slope_div = {8'h00, mod_upper} - {8'h00, mod_floor};
      if (slope_div == 16'd0) begin
        a = mod_amp_min;
      end else begin
        t = t / slope_div;
        amp_span = {8'h00, mod_amp_max} - {8'h00, mod_amp_min};
        prod = {16'h0000, t} * {16'h0000, amp_span};
        t = prod[15:0] / 16'd100;
        if (t > {8'h00, mod_amp_max}) a = mod_amp_min;
        else a = mod_amp_max - t[7:0];
      end
    end
    // only one margin is applied, high first
    hi_room = int'(mod_high_margin) - int'(d);
    lo_room = int'(d) - int'(mod_low_margin);
    if (int'(a) > hi_room) a = hi_room[7:0];
    else if (int'(a) > lo_room) a = lo_room[7:0];
    return a;
  endfunction

  // advance the duty model by one request, returns 1 when a duty comes out
  function automatic bit step_modulator(input cmd_t c, input logic [7:0] req,
                                        output duty_result_t res);
    logic [7:0] d;
    res = '0;
    case (c)
      CMD_RAW: begin
        held_duty = req;
        held_amp = 8'h00;
        held_valid = 1'b1;
      end
      CMD_FMT: begin
        d = req;
        if ((!SVC_BUILD || mod_dither_en) && d < mod_floor) d = mod_floor;
        if (d > mod_cap) d = mod_cap;
        held_duty = d;
        held_amp = mod_dither_en ? dither_amplitude(d) : 8'h00;
        held_valid = 1'b1;
      end
      CMD_TICK: begin
        if (held_valid) begin
          work_duty = {8'h00, held_duty};
          work_amp = held_amp;
        end
        if (mod_dither_en) begin
          if (!phase_up) begin
            work_duty = work_duty - {8'h00, work_amp};
          end else begin
            work_duty = work_duty + {8'h00, work_amp};
            res.dither_high = 1'b1;
          end
          phase_up = !phase_up;
        end
        // underflow wraps high, then clamps
        if (work_duty > 16'h00FF) work_duty = 16'h00FF;
        res.duty_value = {work_duty[7:0], 1'b0};
        return 1'b1;
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // present one request, random gap first, and book its duty once taken
  task automatic send_request(input cmd_t c, input logic [7:0] d, input bit typed,
                              input duty_result_t typed_res);
    int           gap;
    duty_result_t res;
    bit           has_res;
    gap = 0;
    if (!quiet) begin
      while ($urandom_range(99) < IDLE_PCT) gap++;
    end
    @(negedge clk);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= c;
    s_axis_tdata <= d;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    has_res = step_modulator(c, d, res);
    if (has_res) pending_results.push_back(typed ? typed_res : res);
  endtask

  // stop requests, drain all duties, then let a pending formatted write finish
  task automatic settle_block();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [7:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    case (idx)
      REG_DUTY_FLOOR:  mod_floor = v;
      REG_UPPER_POINT: mod_upper = v;
      REG_DUTY_CAP:    mod_cap = v;
      REG_AMP_MAX:     mod_amp_max = v;
      REG_AMP_MIN:     mod_amp_min = v;
      REG_LOW_MARGIN:  mod_low_margin = v;
      REG_HIGH_MARGIN: mod_high_margin = v;
      REG_DITHER_EN:   mod_dither_en = v[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // result side stalls at random except in quiet phases
  always @(negedge clk) begin
    m_axis_tready <= quiet || ($urandom_range(99) >= IDLE_PCT);
  end

  // compare every duty taken with the oldest one owed
  always @(posedge clk) begin
    duty_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected duty, expected none, actual tdata %0d tuser %0d",
                 $time, m_axis_tdata, m_axis_tuser);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata !== {7'b0, want.duty_value}) begin
          $display("%0t: duty_value expected %0d actual %0d",
                   $time, want.duty_value, m_axis_tdata);
          mismatches++;
        end
        if (m_axis_tuser !== want.dither_high) begin
          $display("%0t: dither_high expected %0d actual %0d",
                   $time, want.dither_high, m_axis_tuser);
          mismatches++;
        end
      end
    end
  end

  // watchdog on cycles with no request and no duty taken
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("dithered_pwm_duty_modulator_unit verification failed");
      $finish;
    end
  end

  initial begin
    dir_row_t   row;
    bit         prev_reg;
    cmd_t       c;
    int         roll, base, peak;
    logic [7:0] f, u, cp, amx, amn, lm, hm, en;

    // model starts in the reset state
    mod_floor = 8'h00;
    mod_upper = 8'hFF;
    mod_cap = 8'hFF;
    mod_amp_max = 8'h00;
    mod_amp_min = 8'h00;
    mod_low_margin = 8'h00;
    mod_high_margin = 8'hFF;
    mod_dither_en = 1'b0;
    held_duty = 8'h00;
    held_amp = 8'h00;
    held_valid = 1'b0;
    work_duty = 16'h0000;
    work_amp = 8'h00;
    phase_up = 1'b0;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed table, settle before each run of register writes
    prev_reg = 1'b0;
    for (int i = 0; i < $size(directed_rows); i++) begin
      row = directed_rows[i];
      if (row.is_reg) begin
        if (!prev_reg) settle_block();
        write_reg(row.idx, row.data);
      end else begin
        send_request(row.cmd, row.data, row.typed, row.typed_res);
      end
      prev_reg = row.is_reg;
    end

    // random phases, each with its own settings
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      settle_block();
      quiet = (phase == 5) || (phase == 6);
      if (phase < 2) begin
        // all registers at one extreme
        f = (phase == 0) ? 8'h00 : 8'hFF;
        u = f; cp = f; amx = f; amn = f; lm = f; hm = f; en = f;
      end else if (phase % 4 != 3) begin
        // sane ordering so the slope path is exercised
        base = $urandom_range(120);
        peak = $urandom_range(90);
        f = 8'(base);
        u = 8'($urandom_range(255, base + 1));
        cp = 8'($urandom_range(255, base));
        amx = 8'(peak);
        amn = 8'($urandom_range(peak));
        lm = 8'($urandom_range(40));
        hm = 8'($urandom_range(255, 200));
        en = {7'($urandom_range(127)), 1'(phase % 5 != 4)};
      end else begin
        // anything goes
        f = pick_byte(); u = pick_byte(); cp = pick_byte();
        amx = pick_byte(); amn = pick_byte(); lm = pick_byte(); hm = pick_byte();
        en = {7'($urandom_range(127)), 1'($urandom_range(1))};
      end
      write_reg(REG_DUTY_FLOOR, f);
      write_reg(REG_UPPER_POINT, u);
      write_reg(REG_DUTY_CAP, cp);
      write_reg(REG_AMP_MAX, amx);
      write_reg(REG_AMP_MIN, amn);
      write_reg(REG_LOW_MARGIN, lm);
      write_reg(REG_HIGH_MARGIN, hm);
      write_reg(REG_DITHER_EN, en);

      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        roll = $urandom_range(99);
        if (roll < 45) c = CMD_TICK;
        else if (roll < 80) c = CMD_FMT;
        else if (roll < 93) c = CMD_RAW;
        else c = CMD_NOP;
        send_request(c, pick_byte(), 1'b0, '0);
      end
    end

    quiet = 1'b0;
    settle_block();
    if (mismatches == 0 && pending_results.size() == 0)
      $display("dithered_pwm_duty_modulator_unit verification clean");
    else
      $display("dithered_pwm_duty_modulator_unit verification failed");
    $finish;
  end

endmodule

[dithered_pwm_duty_modulator_unit.f]
+incdir+sv
sv/dpdm_pkg.sv
sv/dpdm_ctrl.sv
sv/dpdm_dp.sv
sv/dithered_pwm_duty_modulator_unit.sv
sv/dpdm_chk.sv
test/tb_dithered_pwm_duty_modulator_unit.sv
